>>> hdl/stdce_pkg.sv
// stdce_pkg: shared types and constants for the shadow table diff command emitter
// no dependencies
`default_nettype none
package stdce_pkg;
  localparam int unsigned CmdCapacityDefault = 128;
  localparam int unsigned PalDepth = 32;
  localparam int unsigned AtrDepth = 64;
  localparam logic [13:0] PalBase = 14'h3F00;
  localparam logic [13:0] AtrBase = 14'h23C0;

  typedef enum logic [2:0] {
    OP_PAL_WR = 3'd0,
    OP_ATR_WR = 3'd1,
    OP_FRAME  = 3'd2,
    OP_SHORT  = 3'd3,
    OP_BUFRST = 3'd4
  } op_code_t;

  localparam logic [1:0] KindVram    = 2'd0;
  localparam logic [1:0] KindShortOk = 2'd1;
  localparam logic [1:0] KindDropped = 2'd2;

  // item handed from front to back
  typedef struct packed {
    logic [2:0] op;
    logic [4:0] pal_index;
    logic [3:0] block_col;
    logic [3:0] block_row;
    logic [7:0] value;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [13:0] vram_addr;
    logic [7:0]  data;
    logic        last;
  } res_t;
endpackage
`default_nettype wire

>>> hdl/stdce_fifo.sv
// stdce_fifo: small two-entry queue of a packed payload
// depends on nothing
`default_nettype none
module stdce_fifo #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr,
  input  wire logic [Width-1:0] wdata,
  output logic                  full,
  input  wire logic             rd,
  output logic [Width-1:0]      rdata,
  output logic                  empty
);
  logic [Width-1:0] mem_r [2];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic             do_wr, do_rd;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem_r[rp_r];

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_wr) wp_r <= !wp_r;
      if (do_rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wdata;
  end
endmodule
`default_nettype wire

>>> hdl/stdce_back.sv
// stdce_back: table state, frame scan and short command budget
// depends on stdce_pkg
`default_nettype none
module stdce_back
  import stdce_pkg::*;
#(
  parameter int unsigned CmdCapacity = CmdCapacityDefault
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_take,
  output logic      res_push,
  output res_t      res,
  input  wire logic res_full
);
  typedef enum logic [2:0] {S_IDLE, S_ATR, S_RD, S_CMP, S_FLUSH} state_t;

  // tables: index 0..31 palette, 32..95 attribute (7 bit)
  logic [7:0]  now_r  [96];
  logic [7:0]  sent_r [96];
  logic [95:0] valid_r;
  logic [95:0] svalid_r;

  state_t      state_r;
  logic [6:0]  idx_r;
  logic [6:0]  aidx_r;
  logic [1:0]  q_r;
  logic [1:0]  aval_r;
  logic [7:0]  fill_r;
  logic [7:0]  now_q_r, sent_q_r;
  res_t        pend_r;
  logic        pend_v_r;
  logic [6:0]  aidx;
  logic [7:0]  atr_new;
  logic        room, can_write, is_last_idx, differs, short_drop;
  logic        short_push, scan_emit, flush_push, res_push_nxt;
  res_t        res_nxt;
  logic [13:0] addr;

  assign aidx = 7'd32 + {1'b0, cmd.block_row[3:1], cmd.block_col[3:1]};

  // merge the new quadrant into the attribute byte read last cycle
  always_comb begin
    atr_new = now_q_r;
    case (q_r)
      2'd0: atr_new[1:0] = aval_r;
      2'd1: atr_new[3:2] = aval_r;
      2'd2: atr_new[5:4] = aval_r;
      default: atr_new[7:6] = aval_r;
    endcase
  end

  assign differs     = (now_q_r != sent_q_r);
  assign can_write   = ({1'b0, fill_r} + 9'd2) < 9'(CmdCapacity);
  assign short_drop  = ({1'b0, fill_r} >= 9'(CmdCapacity));
  assign is_last_idx = (idx_r == 7'd95);
  assign addr = (idx_r < 7'd32) ? PalBase + 14'(idx_r)
                                : AtrBase + 14'(idx_r - 7'd32);

  // room: queue not full and no transfer still on its way in
  assign room = !res_full && !res_push;

  // accept commands only when idle and room for a result
  assign cmd_take = (state_r == S_IDLE) && cmd_valid && room;

  // result selection; a write is held back until the next one or the scan end
  assign short_push   = cmd_take && (cmd.op == OP_SHORT);
  assign scan_emit    = (state_r == S_CMP) && room && differs && can_write;
  assign flush_push   = (state_r == S_FLUSH) && pend_v_r && room;
  assign res_push_nxt = short_push || flush_push || (scan_emit && pend_v_r);
  always_comb begin
    if (short_push) begin
      res_nxt = '{kind: short_drop ? KindDropped : KindShortOk, vram_addr: 14'd0,
                  data: cmd.value, last: 1'b1};
    end else begin
      res_nxt = '{kind: pend_r.kind, vram_addr: pend_r.vram_addr, data: pend_r.data,
                  last: (state_r == S_FLUSH)};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_push <= 1'b0;
    end else begin
      res_push <= res_push_nxt;
      if (res_push_nxt) res <= res_nxt;
    end
  end

  // sequencer, tables and budget
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fill_r   <= 8'd2;
      idx_r    <= '0;
      pend_v_r <= 1'b0;
      valid_r  <= '0;
      svalid_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: if (cmd_take) begin
          case (op_code_t'(cmd.op))
            OP_PAL_WR: begin
              now_r[{2'b00, cmd.pal_index}]   <= cmd.value;
              valid_r[{2'b00, cmd.pal_index}] <= 1'b1;
            end
            OP_ATR_WR: begin
              aidx_r  <= aidx;
              q_r     <= {cmd.block_row[0], cmd.block_col[0]};
              aval_r  <= cmd.value[1:0];
              now_q_r <= valid_r[aidx] ? now_r[aidx] : 8'd0;
              state_r <= S_ATR;
            end
            OP_FRAME: begin
              idx_r   <= '0;
              state_r <= S_RD;
            end
            OP_SHORT: if (!short_drop) fill_r <= fill_r + 8'd1;
            OP_BUFRST: fill_r <= 8'd2;
            default: ;
          endcase
        end
        // write back the merged attribute byte
        S_ATR: begin
          now_r[aidx_r]   <= atr_new;
          valid_r[aidx_r] <= 1'b1;
          state_r         <= S_IDLE;
        end
        // fetch one entry pair
        S_RD: begin
          now_q_r  <= valid_r[idx_r] ? now_r[idx_r] : 8'd0;
          sent_q_r <= svalid_r[idx_r] ? sent_r[idx_r] : 8'd0;
          state_r  <= S_CMP;
        end
        // compare and emit; wait for room
        S_CMP: if (room) begin
          if (scan_emit) begin
            fill_r          <= fill_r + 8'd3;
            sent_r[idx_r]   <= now_q_r;
            svalid_r[idx_r] <= 1'b1;
            pend_r          <= '{kind: KindVram, vram_addr: addr, data: now_q_r,
                                 last: 1'b0};
            pend_v_r        <= 1'b1;
            if (is_last_idx) state_r <= S_FLUSH;
            else begin
              idx_r   <= idx_r + 7'd1;
              state_r <= S_RD;
            end
          end else if (differs || is_last_idx) begin
            // budget refused or table end: scan ends
            state_r <= S_FLUSH;
          end else begin
            idx_r   <= idx_r + 7'd1;
            state_r <= S_RD;
          end
        end
        // send the held write marked as last
        S_FLUSH: begin
          if (!pend_v_r) state_r <= S_IDLE;
          else if (room) begin
            pend_v_r <= 1'b0;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // assertions
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, fill_r} <= 9'(CmdCapacity) + 9'd2))
    else $error("fill count out of range");
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result pushed into full queue");
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> (state_r == S_IDLE))
    else $error("command taken while busy");
  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_v_r)
    else $error("held write left behind after scan");
endmodule
`default_nettype wire

>>> hdl/shadow_table_diff_command_emitter.sv
// shadow_table_diff_command_emitter: top level
// Use: push op and fields through in_push while in_full is low. Results
// appear on out_* while out_empty is low; out_pop takes one.
// Table writes and buffer reset give no result; an attribute write is a
// read, then a merge and write. A short command gives one result,
// registered in the back end and then queued. A frame update walks 96
// entries, one table read and one compare per entry, then sends the final
// held write; a stall on the result side holds it. Each differing entry
// gives one write while the budget allows; a differing entry that does
// not fit ends the scan. Each write is held one step so the last result
// of a frame update can carry out_last. One command is worked on at a
// time; a two-entry input queue lets the sender run ahead.
// Reset (synchronous, rst_n low) clears all tables and sets the fill count
// to 2 at once. When the receiver stalls, the scan holds until the
// result queue has room; nothing is lost.
// depends on stdce_pkg, stdce_fifo, stdce_back
`default_nettype none
module shadow_table_diff_command_emitter
  import stdce_pkg::*;
#(
  parameter int unsigned CMD_CAPACITY = CmdCapacityDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [2:0]  in_op,
  input  wire logic [4:0]  in_pal_index,
  input  wire logic [3:0]  in_block_col,
  input  wire logic [3:0]  in_block_row,
  input  wire logic [7:0]  in_value,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [1:0]       out_kind,
  output logic [13:0]      out_vram_addr,
  output logic [7:0]       out_data,
  output logic             out_last
);
  cmd_t cmd_in, cmd_q;
  logic cmd_empty, cmd_take, res_push, res_full;
  res_t res, res_q;
  logic fifo_empty, rq_full;

  assign cmd_in = '{op: in_op, pal_index: in_pal_index, block_col: in_block_col,
                    block_row: in_block_row, value: in_value};

  // front: command queue
  stdce_fifo #(.Width($bits(cmd_t))) u_cmdq (
    .clk, .rst_n, .wr(in_push), .wdata(cmd_in), .full(in_full),
    .rd(cmd_take), .rdata(cmd_q), .empty(cmd_empty));

  stdce_back #(.CmdCapacity(CMD_CAPACITY)) u_back (
    .clk, .rst_n, .cmd_valid(!cmd_empty), .cmd(cmd_q), .cmd_take,
    .res_push, .res, .res_full);

  // result queue toward the receiver
  stdce_fifo #(.Width($bits(res_t))) u_resq (
    .clk, .rst_n, .wr(res_push), .wdata(res), .full(rq_full),
    .rd(out_pop && !out_empty), .rdata(res_q), .empty(fifo_empty));
  assign res_full      = rq_full;
  assign out_empty     = fifo_empty;
  assign out_kind      = res_q.kind;
  assign out_vram_addr = res_q.vram_addr;
  assign out_data      = res_q.data;
  assign out_last      = res_q.last;
endmodule
`default_nettype wire
